FILE: src/scdf_pkg.sv
// ----------------------------------------------------------------------------
// scdf_pkg
// Shared types, constants and the control program of the display framer.
// ----------------------------------------------------------------------------
package scdf_pkg;

    localparam int TEXT_DEPTH = 256;
    localparam int AW         = $clog2(TEXT_DEPTH);
    localparam int DIGITS     = 8;
    localparam int SLOT_W     = $clog2(DIGITS);
    localparam int LEN_W      = 9;
    localparam int OFF_W      = 10;
    localparam int IDX_W      = OFF_W + 1;

    typedef logic [AW-1:0]     addr_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [7:0]        char_t;

    localparam char_t CH_LOW     = 8'h20;
    localparam char_t CH_HIGH    = 8'h5f;
    localparam char_t STROBES    = 8'h0C;
    localparam char_t ADDR_MASK  = 8'h03;
    localparam char_t SEL_SECOND = 8'hF7;
    localparam char_t SEL_FIRST  = 8'hFB;
    localparam off_t  OFFSET_RESTART = 10'h3F8;
    localparam slot_t SLOT_LAST  = slot_t'(DIGITS - 1);

    typedef enum logic [1:0] {
        KIND_DIRECT  = 2'd0,
        KIND_LOAD    = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_TICK    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_READ,
        OP_CHECK,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        FR_FIRST,
        FR_PULSE,
        FR_CLOSE
    } fsel_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_DISPATCH,
        J_SLOT,
        J_EMIT
    } jmp_t;

    typedef logic [2:0] step_t;

    localparam step_t ST_IDLE   = 3'd0;
    localparam step_t ST_FETCH  = 3'd1;
    localparam step_t ST_CHECK  = 3'd2;
    localparam step_t ST_UPDATE = 3'd3;
    localparam step_t ST_EMIT0  = 3'd4;
    localparam step_t ST_EMIT1  = 3'd5;
    localparam step_t ST_EMIT2  = 3'd6;

    typedef struct packed {
        op_t   op;
        fsel_t fsel;
        jmp_t  jump;
        step_t next_step;
        step_t alt_step;
    } ctrl_t;

    typedef struct packed {
        logic  in_fire;
        kind_t kind;
        logic  slot_last;
        logic  out_free;
        logic  frame_done;
    } stat_t;

    // Control store: one word per step.
    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t w;
        case (pc)
            ST_IDLE:   w = '{OP_ACCEPT, FR_FIRST, J_DISPATCH, ST_EMIT0,  ST_FETCH};
            ST_FETCH:  w = '{OP_READ,   FR_FIRST, J_NEXT,     ST_CHECK,  ST_IDLE};
            ST_CHECK:  w = '{OP_CHECK,  FR_FIRST, J_SLOT,     ST_FETCH,  ST_UPDATE};
            ST_UPDATE: w = '{OP_UPDATE, FR_FIRST, J_NEXT,     ST_EMIT0,  ST_IDLE};
            ST_EMIT0:  w = '{OP_EMIT,   FR_FIRST, J_EMIT,     ST_EMIT1,  ST_IDLE};
            ST_EMIT1:  w = '{OP_EMIT,   FR_PULSE, J_EMIT,     ST_EMIT2,  ST_IDLE};
            ST_EMIT2:  w = '{OP_EMIT,   FR_CLOSE, J_EMIT,     ST_EMIT0,  ST_IDLE};
            default:   w = '{OP_NOP,    FR_FIRST, J_NEXT,     ST_IDLE,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: src/scdf_ram.sv
// ----------------------------------------------------------------------------
// scdf_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/scdf_seq.sv
// ----------------------------------------------------------------------------
// scdf_seq
// Step counter and jump logic over the control store.
// ----------------------------------------------------------------------------
module scdf_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  scdf_pkg::stat_t  stat,
    output scdf_pkg::ctrl_t  ctrl
);

    scdf_pkg::step_t pc_reg;
    scdf_pkg::step_t pc_next;

    assign ctrl = scdf_pkg::ucode(pc_reg);

    always_comb
    begin
        pc_next = pc_reg;
        case (ctrl.jump)
            scdf_pkg::J_NEXT:
            begin
                pc_next = ctrl.next_step;
            end
            scdf_pkg::J_DISPATCH:
            begin
                if (stat.in_fire && stat.kind == scdf_pkg::KIND_DIRECT)
                begin
                    pc_next = ctrl.next_step;
                end
                else if (stat.in_fire && stat.kind == scdf_pkg::KIND_TICK)
                begin
                    pc_next = ctrl.alt_step;
                end
            end
            scdf_pkg::J_SLOT:
            begin
                pc_next = stat.slot_last ? ctrl.alt_step : ctrl.next_step;
            end
            scdf_pkg::J_EMIT:
            begin
                // hold until the output word is free
                if (stat.out_free)
                begin
                    pc_next = stat.frame_done ? ctrl.alt_step : ctrl.next_step;
                end
            end
            default:
            begin
                pc_next = scdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= scdf_pkg::ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: src/scdf_datapath.sv
// ----------------------------------------------------------------------------
// scdf_datapath
// Text store, scroll window, frame builder and output word register.
// ----------------------------------------------------------------------------
module scdf_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  scdf_pkg::ctrl_t  ctrl,
    output scdf_pkg::stat_t  stat,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    scdf_pkg::kind_t in_kind;
    scdf_pkg::char_t in_pos;
    scdf_pkg::char_t in_idx;
    scdf_pkg::char_t in_ch;
    logic            in_fire;
    logic            load_ok;

    scdf_pkg::off_t  offset_reg;
    scdf_pkg::len_t  length_reg;
    scdf_pkg::slot_t slot_reg;
    logic            ended_reg;
    logic            turn_reg;
    logic            neg_reg;
    logic            past_reg;
    logic            direct_reg;
    scdf_pkg::char_t pos_reg;
    scdf_pkg::char_t ch_reg;
    scdf_pkg::char_t win_reg [scdf_pkg::DIGITS];

    scdf_pkg::idx_t  win_sum;
    logic            past_len;
    logic            past_depth;
    scdf_pkg::char_t rdata;

    scdf_pkg::char_t cur_ch;
    scdf_pkg::char_t cur_pos;
    logic            bad;
    scdf_pkg::char_t lo0;
    scdf_pkg::char_t lo1;
    scdf_pkg::char_t lo_sel;
    logic            slot_last;
    logic            out_free;
    logic            emit_fire;
    logic            frame_done;

    logic            out_valid_reg;
    logic [15:0]     out_frame_reg;
    logic            out_err_reg;
    logic            out_turn_reg;
    logic            out_last_reg;

    assign in_kind  = scdf_pkg::kind_t'(s_tuser);
    assign in_pos   = s_tdata[7:0];
    assign in_idx   = s_tdata[15:8];
    assign in_ch    = s_tdata[23:16];
    assign s_tready = (ctrl.op == scdf_pkg::OP_ACCEPT);
    assign in_fire  = s_tready && s_tvalid;
    assign load_ok  = in_fire && in_kind == scdf_pkg::KIND_LOAD
                      && (32'(in_idx) < 32'(scdf_pkg::TEXT_DEPTH));

    // window index = signed offset + slot
    assign win_sum    = scdf_pkg::idx_t'({offset_reg[scdf_pkg::OFF_W-1], offset_reg})
                        + scdf_pkg::idx_t'(slot_reg);
    assign past_len   = win_sum[scdf_pkg::OFF_W-1:0] >= scdf_pkg::off_t'(length_reg);
    assign past_depth = 32'(win_sum[scdf_pkg::OFF_W-1:0]) >= 32'(scdf_pkg::TEXT_DEPTH);

    scdf_ram #(
        .WIDTH (8),
        .DEPTH (scdf_pkg::TEXT_DEPTH)
    ) u_text (
        .clk   (clk),
        .we    (load_ok && in_ch != 8'd0),
        .waddr (scdf_pkg::addr_t'(in_idx)),
        .wdata (in_ch),
        .re    (ctrl.op == scdf_pkg::OP_READ),
        .raddr (scdf_pkg::addr_t'(win_sum[scdf_pkg::OFF_W-1:0])),
        .rdata (rdata)
    );

    // frame builder
    assign cur_ch    = direct_reg ? ch_reg : win_reg[slot_reg];
    assign cur_pos   = direct_reg ? pos_reg : scdf_pkg::char_t'(slot_reg);
    assign bad       = cur_ch < scdf_pkg::CH_LOW || cur_ch > scdf_pkg::CH_HIGH
                       || cur_pos[7:3] != 5'd0;
    assign lo0       = scdf_pkg::STROBES | (~cur_pos & scdf_pkg::ADDR_MASK);
    assign lo1       = lo0 & (cur_pos[2] ? scdf_pkg::SEL_SECOND : scdf_pkg::SEL_FIRST);
    assign slot_last = slot_reg == scdf_pkg::SLOT_LAST;
    assign out_free  = !out_valid_reg || m_tready;
    assign emit_fire = ctrl.op == scdf_pkg::OP_EMIT && out_free;

    always_comb
    begin
        case (ctrl.fsel)
            scdf_pkg::FR_FIRST: lo_sel = lo0;
            scdf_pkg::FR_PULSE: lo_sel = lo1;
            scdf_pkg::FR_CLOSE: lo_sel = lo1 | scdf_pkg::STROBES;
            default:            lo_sel = lo0;
        endcase
    end

    assign frame_done = (ctrl.fsel == scdf_pkg::FR_FIRST && bad)
                        || (ctrl.fsel == scdf_pkg::FR_CLOSE && (direct_reg || slot_last));

    assign stat = '{in_fire, in_kind, slot_last, out_free, frame_done};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            length_reg    <= '0;
            slot_reg      <= '0;
            ended_reg     <= 1'b0;
            turn_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            past_reg      <= 1'b0;
            direct_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                slot_reg   <= '0;
                ended_reg  <= 1'b0;
                turn_reg   <= 1'b0;
                direct_reg <= in_kind == scdf_pkg::KIND_DIRECT;
                if (in_kind == scdf_pkg::KIND_RESTART)
                begin
                    offset_reg <= scdf_pkg::OFFSET_RESTART;
                end
                if (load_ok && in_ch == 8'd0)
                begin
                    length_reg <= scdf_pkg::len_t'(in_idx);
                end
            end

            if (ctrl.op == scdf_pkg::OP_READ)
            begin
                neg_reg  <= win_sum[scdf_pkg::IDX_W-1];
                past_reg <= past_len || past_depth;
            end

            if (ctrl.op == scdf_pkg::OP_CHECK)
            begin
                if (!ended_reg && !neg_reg && (past_reg || rdata == 8'd0))
                begin
                    ended_reg <= 1'b1;
                    // end met in the first two slots restarts the scroll
                    if (slot_reg <= scdf_pkg::slot_t'(1))
                    begin
                        turn_reg <= 1'b1;
                    end
                end
                if (!slot_last)
                begin
                    slot_reg <= slot_reg + scdf_pkg::slot_t'(1);
                end
            end

            if (ctrl.op == scdf_pkg::OP_UPDATE)
            begin
                slot_reg   <= '0;
                offset_reg <= turn_reg ? scdf_pkg::OFFSET_RESTART
                                       : offset_reg + scdf_pkg::off_t'(1);
            end

            if (emit_fire && ctrl.fsel == scdf_pkg::FR_CLOSE && !frame_done)
            begin
                slot_reg <= slot_reg + scdf_pkg::slot_t'(1);
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pos_reg <= in_pos;
            ch_reg  <= in_ch;
        end
        if (ctrl.op == scdf_pkg::OP_CHECK)
        begin
            if (!ended_reg && !neg_reg && !past_reg && rdata != 8'd0)
            begin
                win_reg[slot_reg] <= rdata;
            end
            else
            begin
                win_reg[slot_reg] <= scdf_pkg::CH_LOW;
            end
        end
        if (emit_fire)
        begin
            out_turn_reg <= turn_reg;
            out_last_reg <= frame_done;
            if (ctrl.fsel == scdf_pkg::FR_FIRST && bad)
            begin
                out_frame_reg <= 16'd0;
                out_err_reg   <= 1'b1;
            end
            else
            begin
                out_frame_reg <= {cur_ch, lo_sel};
                out_err_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_frame_reg;
    assign m_tuser  = {out_turn_reg, out_err_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: src/scrolling_char_display_framer_top.sv
// ----------------------------------------------------------------------------
// scrolling_char_display_framer_top
// Character display framer with a scrolling text window.
// ----------------------------------------------------------------------------
// Input stream: s_tuser holds the kind (direct write, text load, restart,
// tick); s_tdata holds position, text index and character. Output stream:
// one 16-bit shift word per beat on m_tdata, error and wrap flag on m_tuser,
// m_tlast on the final word an input causes.
// A direct write gives three words (or one error word), loaded by the emit
// steps that follow acceptance, one per cycle while the receiver takes them;
// the next input is taken after the last word is loaded.
// Text loads and restarts complete in their accept cycle.
// A tick first reads the eight window characters from the text RAM, two
// steps each of the control program (address, then check of registered
// data), then one update step, then up to 24 words, one per cycle while
// the receiver takes them.
// Reset clears text length, scroll offset and the output valid flag; the
// text RAM content is unknown until loaded.
// When the receiver stalls, the held word stays and the program waits in
// its emit step; no word is lost or repeated.
// ----------------------------------------------------------------------------
module scrolling_char_display_framer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // position[7:0], text_index[15:8], character[23:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // frame[15:0]
    output logic [1:0]  m_tuser,   // error[0], wrap[1]
    output logic        m_tlast
);

    scdf_pkg::ctrl_t ctrl;
    scdf_pkg::stat_t stat;

    scdf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    scdf_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // an error word is empty and ends its item
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0 && m_tlast)
        else $error("error word not empty or not last");

    // no new item while a non-final word is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken with an item in flight");

    // at most one device strobe low per frame
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[3:2] != 2'b00)
        else $error("both write strobes low");

endmodule
